/* design/rgbbd_pkg.sv */
`timescale 1ns / 1ps

package rgbbd_pkg;

	localparam int FRAME_WIDTH  = 64;
	localparam int FRAME_HEIGHT = 64;
	localparam int BLOCK_SIDE   = 4;

	localparam int OUT_COLS   = FRAME_WIDTH / BLOCK_SIDE;
	localparam int OUT_ROWS   = FRAME_HEIGHT / BLOCK_SIDE;
	localparam int BLOCK_AREA = BLOCK_SIDE * BLOCK_SIDE;
	localparam int COLS_USED  = OUT_COLS * BLOCK_SIDE;
	localparam int ROWS_USED  = OUT_ROWS * BLOCK_SIDE;

	localparam int COL_W = $clog2(FRAME_WIDTH);
	localparam int ROW_W = $clog2(FRAME_HEIGHT);
	localparam int DX_W  = $clog2(BLOCK_SIDE);
	localparam int BX_W  = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1;
	localparam int BY_W  = (OUT_ROWS > 1) ? $clog2(OUT_ROWS) : 1;

	localparam int PIX_W  = 16;
	localparam int RED_W  = 5;
	localparam int GRN_W  = 6;
	localparam int BLU_W  = 5;
	localparam int RED_LSB = 11;
	localparam int GRN_LSB = 5;

	localparam int AREA_LOG = $clog2(BLOCK_AREA);
	localparam int SUMR_W   = RED_W + AREA_LOG;
	localparam int SUMG_W   = GRN_W + AREA_LOG;
	localparam int SUMB_W   = BLU_W + AREA_LOG;

	// Exact division by the block area: multiply by a rounded-up reciprocal.
	localparam int DIV_SHIFT = SUMG_W + AREA_LOG;
	localparam int RECIP_W   = SUMG_W + 1;
	localparam int RECIP     = ((2 ** DIV_SHIFT) + BLOCK_AREA - 1) / BLOCK_AREA;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [BX_W-1:0]  bx;
		logic             first;
		logic             last;
		logic             frame_last;
		logic [PIX_W-1:0] pixel;
	} op_t;

	typedef struct packed {
		logic [SUMR_W-1:0] red;
		logic [SUMG_W-1:0] grn;
		logic [SUMB_W-1:0] blu;
	} sums_t;

	function automatic logic [GRN_W-1:0] avg_of(input logic [SUMG_W-1:0] s);
		logic [SUMG_W+RECIP_W-1:0] prod;
		prod = SUMG_W'(s) * RECIP_W'(RECIP);
		return prod[DIV_SHIFT +: GRN_W];
	endfunction

endpackage

/* design/rgbbd_pix_if.sv */
`timescale 1ns / 1ps

interface rgbbd_pix_if;
	logic                        valid;
	logic                        ready;
	logic [rgbbd_pkg::PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

/* design/rgbbd_avg_if.sv */
`timescale 1ns / 1ps

interface rgbbd_avg_if;
	logic                        valid;
	logic                        ready;
	logic [rgbbd_pkg::PIX_W-1:0] avg_pixel;
	logic                        frame_last;

	modport source (output valid, output avg_pixel, output frame_last, input ready);
	modport sink (input valid, input avg_pixel, input frame_last, output ready);
endinterface

/* design/rgb565_box_downsample.sv */
`timescale 1ns / 1ps

// RGB565 box-filter downsampler.
// The pix channel takes RGB565 pixels of a FRAME_WIDTH x FRAME_HEIGHT frame in
// raster order, one transfer per pixel. The avg channel delivers one RGB565
// pixel per BLOCK_SIDE x BLOCK_SIDE block, the truncated mean of each color
// channel, in raster order of the output grid; frame_last marks the frame's
// final block. Columns and rows beyond the last full block are taken and ignored.
// Throughput is one pixel per cycle while the queue has room, set by the
// read-add-write of the per-column sum registers in the back end.
// After a block's last pixel is taken, its op passes through the four-entry op
// queue; the back end takes it once the output register is free or being read,
// and loads the result into the output register, which drives avg.valid.
// Reset returns the frame position to the first pixel and empties the queue
// and the output register; the sum registers need no clearing because each
// block's first pixel overwrites its entry.
// When the receiver stalls, the result waits in the output register while
// pixels keep flowing until the queue holds a block's last pixel at its head;
// the queue then fills and pix.ready drops.

module rgb565_box_downsample (
	input  logic        clk,
	input  logic        arst_n,
	rgbbd_pix_if.sink   pix,
	rgbbd_avg_if.source avg
);

	logic           q_push;
	logic           q_ready;
	rgbbd_pkg::op_t q_in_op;
	logic           op_valid;
	logic           op_ready;
	rgbbd_pkg::op_t op;

	rgbbd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix),
		.q_ready (q_ready),
		.q_push  (q_push),
		.q_op    (q_in_op)
	);

	rgbbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_op    (q_in_op),
		.push_ready (q_ready),
		.pop_valid  (op_valid),
		.pop_op     (op),
		.pop        (op_ready)
	);

	rgbbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_ready (op_ready),
		.avg      (avg)
	);

endmodule

/* design/rgbbd_front.sv */
`timescale 1ns / 1ps

module rgbbd_front (
	input  logic              clk,
	input  logic              arst_n,
	rgbbd_pix_if.sink         pix,
	input  logic              q_ready,
	output logic              q_push,
	output rgbbd_pkg::op_t    q_op
);

	logic [rgbbd_pkg::COL_W-1:0] col_q;
	logic [rgbbd_pkg::ROW_W-1:0] row_q;
	logic [rgbbd_pkg::DX_W-1:0]  dx_q;
	logic [rgbbd_pkg::DX_W-1:0]  dy_q;
	logic [rgbbd_pkg::BX_W-1:0]  bx_q;
	logic [rgbbd_pkg::BY_W-1:0]  by_q;
	logic                        take;
	logic                        in_range;
	logic                        dx_end;
	logic                        dy_end;
	logic                        col_end;
	logic                        row_end;

	assign pix.ready = q_ready;
	assign take      = pix.valid && q_ready;

	assign dx_end  = dx_q == rgbbd_pkg::DX_W'(rgbbd_pkg::BLOCK_SIDE - 1);
	assign dy_end  = dy_q == rgbbd_pkg::DX_W'(rgbbd_pkg::BLOCK_SIDE - 1);
	assign col_end = col_q == rgbbd_pkg::COL_W'(rgbbd_pkg::FRAME_WIDTH - 1);
	assign row_end = row_q == rgbbd_pkg::ROW_W'(rgbbd_pkg::FRAME_HEIGHT - 1);

	assign in_range = ({1'b0, col_q} < (rgbbd_pkg::COL_W + 1)'(rgbbd_pkg::COLS_USED))
		&& ({1'b0, row_q} < (rgbbd_pkg::ROW_W + 1)'(rgbbd_pkg::ROWS_USED));

	assign q_push           = take && in_range;
	assign q_op.bx          = bx_q;
	assign q_op.first       = (dx_q == '0) && (dy_q == '0);
	assign q_op.last        = dx_end && dy_end;
	assign q_op.frame_last  = dx_end && dy_end
		&& (bx_q == rgbbd_pkg::BX_W'(rgbbd_pkg::OUT_COLS - 1))
		&& (by_q == rgbbd_pkg::BY_W'(rgbbd_pkg::OUT_ROWS - 1));
	assign q_op.pixel       = pix.pixel_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			dx_q  <= '0;
			dy_q  <= '0;
			bx_q  <= '0;
			by_q  <= '0;
		end else if (take) begin
			if (col_end) begin
				col_q <= '0;
				dx_q  <= '0;
				bx_q  <= '0;
				if (row_end) begin
					row_q <= '0;
					dy_q  <= '0;
					by_q  <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					dy_q  <= dy_end ? '0 : dy_q + 1'b1;
					if (dy_end && by_q != rgbbd_pkg::BY_W'(rgbbd_pkg::OUT_ROWS - 1)) begin
						by_q <= by_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
				dx_q  <= dx_end ? '0 : dx_q + 1'b1;
				if (dx_end && bx_q != rgbbd_pkg::BX_W'(rgbbd_pkg::OUT_COLS - 1)) begin
					bx_q <= bx_q + 1'b1;
				end
			end
		end
	end

endmodule

/* design/rgbbd_queue.sv */
`timescale 1ns / 1ps

module rgbbd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rgbbd_pkg::op_t push_op,
	output logic           push_ready,
	output logic           pop_valid,
	output rgbbd_pkg::op_t pop_op,
	input  logic           pop
);

	rgbbd_pkg::op_t                entries_q [rgbbd_pkg::QUEUE_DEPTH];
	logic [rgbbd_pkg::QPTR_W-1:0]  wptr_q;
	logic [rgbbd_pkg::QPTR_W-1:0]  rptr_q;
	logic [rgbbd_pkg::QCNT_W-1:0]  count_q;
	logic                          do_pop;

	assign push_ready = count_q != rgbbd_pkg::QCNT_W'(rgbbd_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_op     = entries_q[rptr_q];
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_ready)
		else $error("queue written while full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rgbbd_pkg::QCNT_W'(rgbbd_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");
`endif

endmodule

/* design/rgbbd_back.sv */
`timescale 1ns / 1ps

module rgbbd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	input  rgbbd_pkg::op_t op,
	output logic           op_ready,
	rgbbd_avg_if.source    avg
);

	rgbbd_pkg::sums_t            sums_q [rgbbd_pkg::OUT_COLS];
	rgbbd_pkg::sums_t            rd_sums;
	rgbbd_pkg::sums_t            new_sums;
	logic                        fire;
	logic                        out_valid_q;
	logic [rgbbd_pkg::PIX_W-1:0] avg_pixel_q;
	logic                        frame_last_q;
	logic [rgbbd_pkg::RED_W-1:0] px_red;
	logic [rgbbd_pkg::GRN_W-1:0] px_grn;
	logic [rgbbd_pkg::BLU_W-1:0] px_blu;
	logic [rgbbd_pkg::GRN_W-1:0] avg_red;
	logic [rgbbd_pkg::GRN_W-1:0] avg_grn;
	logic [rgbbd_pkg::GRN_W-1:0] avg_blu;

	assign px_red = op.pixel[rgbbd_pkg::RED_LSB +: rgbbd_pkg::RED_W];
	assign px_grn = op.pixel[rgbbd_pkg::GRN_LSB +: rgbbd_pkg::GRN_W];
	assign px_blu = op.pixel[0 +: rgbbd_pkg::BLU_W];

	assign op_ready = !op.last || !out_valid_q || avg.ready;
	assign fire     = op_valid && op_ready;
	assign rd_sums  = sums_q[op.bx];

	always_comb begin
		if (op.first) begin
			new_sums.red = rgbbd_pkg::SUMR_W'(px_red);
			new_sums.grn = rgbbd_pkg::SUMG_W'(px_grn);
			new_sums.blu = rgbbd_pkg::SUMB_W'(px_blu);
		end else begin
			new_sums.red = rd_sums.red + rgbbd_pkg::SUMR_W'(px_red);
			new_sums.grn = rd_sums.grn + rgbbd_pkg::SUMG_W'(px_grn);
			new_sums.blu = rd_sums.blu + rgbbd_pkg::SUMB_W'(px_blu);
		end
	end

	assign avg_red = rgbbd_pkg::avg_of(rgbbd_pkg::SUMG_W'(new_sums.red));
	assign avg_grn = rgbbd_pkg::avg_of(new_sums.grn);
	assign avg_blu = rgbbd_pkg::avg_of(rgbbd_pkg::SUMG_W'(new_sums.blu));

	always_ff @(posedge clk) begin
		if (fire) begin
			sums_q[op.bx] <= new_sums;
		end
		if (fire && op.last) begin
			avg_pixel_q  <= {avg_red[rgbbd_pkg::RED_W-1:0], avg_grn,
				avg_blu[rgbbd_pkg::BLU_W-1:0]};
			frame_last_q <= op.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && op.last) begin
			out_valid_q <= 1'b1;
		end else if (avg.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign avg.valid      = out_valid_q;
	assign avg.avg_pixel  = avg_pixel_q;
	assign avg.frame_last = frame_last_q;

`ifndef SYNTHESIS
	a_emit_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op.last) |=> out_valid_q)
		else $error("block end did not produce a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !avg.ready) |=> (out_valid_q && $stable(avg_pixel_q)))
		else $error("pending result overwritten");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import rgbbd_pkg::*;

	localparam int DIRECTED_COUNT = 25;
	localparam int PIXEL_TOTAL    = 1750;
	localparam int QUIET_COUNT    = 300;
	localparam int HOLD_AT        = 500;
	localparam int HOLD_CYCLES    = 300;
	localparam int REPORT_LIMIT   = 10;

	typedef enum int {
		FILL_ONES,
		FILL_ZEROS,
		FILL_BRIGHT,
		FILL_RANDOM
	} block_fill_t;

	typedef struct packed {
		logic [PIX_W-1:0] avg_pixel;
		logic             frame_last;
	} avg_result_t;

	class box_avg_checker;
		avg_result_t        pending_avgs[$];
		logic [COL_W-1:0]   col = '0;
		logic [ROW_W-1:0]   row = '0;
		logic [SUMR_W-1:0]  red_acc[OUT_COLS];
		logic [SUMG_W-1:0]  grn_acc[OUT_COLS];
		logic [SUMB_W-1:0]  blu_acc[OUT_COLS];
		int                 errors = 0;

		function void note_pixel(logic [PIX_W-1:0] px);
			logic [RED_W-1:0] r;
			logic [GRN_W-1:0] g;
			logic [BLU_W-1:0] b;
			int               bx, by, dx, dy;
			avg_result_t      res;
			r = px[RED_LSB +: RED_W];
			g = px[GRN_LSB +: GRN_W];
			b = px[BLU_W-1:0];
			bx = col / BLOCK_SIDE;
			by = row / BLOCK_SIDE;
			dx = col % BLOCK_SIDE;
			dy = row % BLOCK_SIDE;
			if (bx < OUT_COLS && by < OUT_ROWS) begin
				if (dx == 0 && dy == 0) begin
					red_acc[bx] = SUMR_W'(r);
					grn_acc[bx] = SUMG_W'(g);
					blu_acc[bx] = SUMB_W'(b);
				end else begin
					red_acc[bx] += SUMR_W'(r);
					grn_acc[bx] += SUMG_W'(g);
					blu_acc[bx] += SUMB_W'(b);
				end
				if (dx == BLOCK_SIDE - 1 && dy == BLOCK_SIDE - 1) begin
					res.avg_pixel = {RED_W'(red_acc[bx] / BLOCK_AREA),
						GRN_W'(grn_acc[bx] / BLOCK_AREA),
						BLU_W'(blu_acc[bx] / BLOCK_AREA)};
					res.frame_last = (bx == OUT_COLS - 1 && by == OUT_ROWS - 1);
					pending_avgs.push_back(res);
				end
			end
			if (col == FRAME_WIDTH - 1) begin
				col = '0;
				row = (row == FRAME_HEIGHT - 1) ? '0 : row + 1'b1;
			end else begin
				col = col + 1'b1;
			end
		endfunction

		function void check_avg(logic [PIX_W-1:0] avg_px, logic last);
			avg_result_t want;
			if (pending_avgs.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result: avg_pixel=%h frame_last=%b", avg_px, last);
				return;
			end
			want = pending_avgs.pop_front();
			if (want.avg_pixel !== avg_px || want.frame_last !== last) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("mismatch: expected avg_pixel=%h frame_last=%b, got avg_pixel=%h frame_last=%b",
						want.avg_pixel, want.frame_last, avg_px, last);
			end
		endfunction

		function int pending();
			return pending_avgs.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rgbbd_pix_if pix ();
	rgbbd_avg_if avg ();

	rgb565_box_downsample dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.avg(avg)
	);

	box_avg_checker checker_h;
	int             pixels_sent = 0;
	bit             quiet_tail = 0;
	bit             sink_holding = 0;
	bit             held_once = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_pixel(input logic [PIX_W-1:0] px);
		pix.valid <= 1'b1;
		pix.pixel_in <= px;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		checker_h.note_pixel(px);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic idle_source(input int cycles);
		pix.valid <= 1'b0;
		pix.pixel_in <= PIX_W'($urandom);
		repeat (cycles)
			@(negedge clk);
	endtask

	function automatic logic [PIX_W-1:0] make_pixel(block_fill_t fill);
		case (fill)
			FILL_ONES:   return '1;
			FILL_ZEROS:  return '0;
			FILL_BRIGHT: return {RED_W'($urandom_range(24, 31)), GRN_W'($urandom_range(48, 63)),
				BLU_W'($urandom_range(24, 31))};
			default:     return PIX_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [PIX_W-1:0] directed[DIRECTED_COUNT];
		block_fill_t      fills[OUT_COLS];
		int               col, row, pick;

		directed = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h8000, 16'h0400,
			16'h0020, 16'h0010, 16'h0001, 16'h7BEF, 16'h8410, 16'hFFFF, 16'hFFFF, 16'hF81F,
			16'h07FF, 16'hFFE0, 16'h0841, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000, 16'hFFFF,
			16'h0000, 16'hFFFF};

		checker_h = new();
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.pixel_in = '0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_pixel(directed[i]);
			if ($urandom_range(0, 5) == 0)
				idle_source($urandom_range(1, 19));
		end

		foreach (fills[i])
			fills[i] = FILL_RANDOM;
		for (int n = DIRECTED_COUNT; n < PIXEL_TOTAL; n++) begin
			col = n % FRAME_WIDTH;
			row = (n / FRAME_WIDTH) % FRAME_HEIGHT;
			if (col == 0 && row % BLOCK_SIDE == 0) begin
				foreach (fills[i]) begin
					pick = $urandom_range(0, 9);
					fills[i] = (pick == 0) ? FILL_ONES : (pick == 1) ? FILL_ZEROS :
						(pick < 4) ? FILL_BRIGHT : FILL_RANDOM;
				end
			end
			if (n >= PIXEL_TOTAL - QUIET_COUNT)
				quiet_tail = 1'b1;
			send_pixel(make_pixel(col / BLOCK_SIDE < OUT_COLS ?
				fills[col / BLOCK_SIDE] : FILL_RANDOM));
			if (!quiet_tail && !sink_holding && $urandom_range(0, 9) == 0)
				idle_source($urandom_range(1, 19));
		end
		pix.valid <= 1'b0;

		while (checker_h.pending() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);

		if (checker_h.errors == 0 && checker_h.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		avg.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_once && !quiet_tail && pixels_sent >= HOLD_AT) begin
				sink_holding = 1'b1;
				avg.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				avg.ready <= 1'b1;
				sink_holding = 1'b0;
				held_once = 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				avg.ready <= 1'b0;
				repeat ($urandom_range(1, 19))
					@(negedge clk);
				avg.ready <= 1'b1;
			end else begin
				avg.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && avg.valid && avg.ready)
			checker_h.check_avg(avg.avg_pixel, avg.frame_last);
	end

endmodule
